// ===== rtl/fqs_pkg.sv =====
package fqs_pkg;

    // Request codes
    localparam logic [1:0] REQ_ENQ    = 2'd0;
    localparam logic [1:0] REQ_DEQ    = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int DATA_W = 8;
    localparam int POS_W  = 6;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [DATA_W-1:0] item;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] value_out;
        logic [POS_W-1:0]  position;
        logic              found;
        logic [1:0]        status;
        logic              last;
    } out_t;

endpackage

// ===== rtl/fifo_queue_with_search.sv =====
// Byte FIFO of DEPTH entries in a ring store with a search by value. One
// request is taken at a time; in_ready is low while it runs. Enqueue and
// dequeue answer from the execute state. Search walks from the newest
// entry toward the oldest through one registered memory read port and one
// byte comparator, a read state and a compare state per entry, and stops
// at the first hit (position 0 is the newest entry). Clear emits every
// entry, oldest first, with last set on the final one; on an empty queue
// it gives one result with status empty. A result sits in the output
// register while the next request is already accepted.
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int IDX_W = $clog2(DEPTH);

    logic              res_valid;
    logic              res_ready;
    out_t              res;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;

    fqs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    fqs_mem #(.DEPTH(DEPTH)) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A stalled internal result must hold until the output register takes it
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("internal result changed while stalled");

    // Accepting a request makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready did not drop after accepting a request");

    // No result is produced while idle
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_valid)
        else $error("result produced while idle");

    // A search hit carries status ok, no data and closes the transaction
    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.found |-> res.status == ST_OK && res.value_out == '0 && res.last)
        else $error("malformed search hit result");

endmodule

// ===== rtl/fqs_mem.sv =====
module fqs_mem
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Ring store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, reads every cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fqs_ctrl.sv =====
module fqs_ctrl
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_data,
    output logic              res_valid,
    input  logic              res_ready,
    output out_t              res,
    output logic              mem_wr_en,
    output logic [IDX_W-1:0]  mem_wr_addr,
    output logic [DATA_W-1:0] mem_wr_data,
    output logic [IDX_W-1:0]  mem_rd_addr,
    input  logic [DATA_W-1:0] mem_rd_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DRD  = 3'd4;
    localparam logic [2:0] S_DOUT = 3'd5;

    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  oldest_reg, oldest_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [1:0]        req_reg, req_next;
    logic [DATA_W-1:0] item_reg, item_next;

    logic             is_empty;
    logic             is_full;
    logic             hit;
    logic             last_step;
    logic [IDX_W-1:0] ptr_inc;
    logic [IDX_W-1:0] ptr_dec;
    logic [IDX_W-1:0] oldest_inc;
    logic [IDX_W-1:0] tail_inc;
    logic [IDX_W-1:0] tail_dec;

    // Ring pointer arithmetic with wrap at DEPTH
    assign ptr_inc    = (ptr_reg == IDX_TOP) ? '0 : ptr_reg + IDX_W'(1);
    assign ptr_dec    = (ptr_reg == '0) ? IDX_TOP : ptr_reg - IDX_W'(1);
    assign oldest_inc = (oldest_reg == IDX_TOP) ? '0 : oldest_reg + IDX_W'(1);
    assign tail_inc   = (tail_reg == IDX_TOP) ? '0 : tail_reg + IDX_W'(1);
    assign tail_dec   = (tail_reg == '0) ? IDX_TOP : tail_reg - IDX_W'(1);

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_MAX);
    // The search comparator and the step-end check shared by search and clear
    assign hit       = (mem_rd_data == item_reg);
    assign last_step = ((idx_reg + CNT_W'(1)) == count_reg);

    assign in_ready    = (state_reg == S_IDLE);
    assign mem_rd_addr = (state_reg == S_IDLE || state_reg == S_EXEC) ? oldest_reg : ptr_reg;
    assign mem_wr_addr = tail_reg;
    assign mem_wr_data = item_reg;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        req_next    = req_reg;
        item_next   = item_reg;
        res_valid   = 1'b0;
        res         = '0;
        mem_wr_en   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data.req_type;
                    item_next  = in_data.item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (req_reg)
                    REQ_ENQ:
                    begin
                        res_valid  = 1'b1;
                        res.status = is_full ? ST_FULL : ST_OK;
                        res.last   = 1'b1;
                        if (res_ready)
                        begin
                            if (!is_full)
                            begin
                                mem_wr_en  = 1'b1;
                                tail_next  = tail_inc;
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_IDLE;
                        end
                    end

                    REQ_DEQ:
                    begin
                        res_valid     = 1'b1;
                        res.status    = is_empty ? ST_EMPTY : ST_OK;
                        res.value_out = is_empty ? '0 : mem_rd_data;
                        res.last      = 1'b1;
                        if (res_ready)
                        begin
                            if (!is_empty)
                            begin
                                oldest_next = oldest_inc;
                                count_next  = count_reg - CNT_W'(1);
                            end
                            state_next = S_IDLE;
                        end
                    end

                    REQ_SEARCH:
                    begin
                        if (is_empty)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_EMPTY;
                            res.last   = 1'b1;
                            if (res_ready)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            // scan starts at the newest entry
                            ptr_next   = tail_dec;
                            idx_next   = '0;
                            state_next = S_SRD;
                        end
                    end

                    REQ_CLEAR:
                    begin
                        if (is_empty)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_EMPTY;
                            res.last   = 1'b1;
                            if (res_ready)
                            begin
                                oldest_next = '0;
                                tail_next   = '0;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            ptr_next   = oldest_reg;
                            idx_next   = '0;
                            state_next = S_DRD;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SRD:
            begin
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (hit || last_step)
                begin
                    res_valid    = 1'b1;
                    res.found    = hit;
                    res.position = hit ? POS_W'(idx_reg) : '0;
                    res.status   = ST_OK;
                    res.last     = 1'b1;
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ptr_next   = ptr_dec;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SRD;
                end
            end

            S_DRD:
            begin
                state_next = S_DOUT;
            end

            S_DOUT:
            begin
                res_valid     = 1'b1;
                res.value_out = mem_rd_data;
                res.status    = ST_OK;
                res.last      = last_step;
                if (res_ready)
                begin
                    if (last_step)
                    begin
                        count_next  = '0;
                        oldest_next = '0;
                        tail_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_DRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            oldest_reg <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // Working registers of the current transaction
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        idx_reg  <= idx_next;
        req_reg  <= req_next;
        item_reg <= item_next;
    end

endmodule

// ===== dv/fifo_search_checker.sv =====
`timescale 1ns / 1ps

module fifo_search_checker
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  in_t  in_data,
    input  logic out_valid,
    input  logic out_ready,
    input  out_t out_data,
    output int   pending,
    output int   fail_count
);

    // Shadow copy of the ring store and its pointers
    logic [DATA_W-1:0] ring [DEPTH];
    int unsigned       head_idx;
    int unsigned       occupancy;

    // Results owed by the block, oldest first
    out_t              due_results [$];
    out_t              want;
    int                fails = 0;

    assign fail_count = fails;

    function automatic out_t make_result(input logic [DATA_W-1:0] v,
                                         input logic [POS_W-1:0]  p,
                                         input logic              f,
                                         input logic [1:0]        s,
                                         input logic              l);
        out_t r;
        r.value_out = v;
        r.position  = p;
        r.found     = f;
        r.status    = s;
        r.last      = l;
        return r;
    endfunction

    // Apply one request to the shadow queue and record what it must return
    task automatic run_queue_request(input in_t req);
        int unsigned slot;
        bit          hit;
        begin
            hit = 1'b0;
            case (req.req_type)
                REQ_ENQ:
                begin
                    if (occupancy >= DEPTH)
                    begin
                        due_results.push_back(make_result('0, '0, 1'b0, ST_FULL, 1'b1));
                    end
                    else
                    begin
                        ring[(head_idx + occupancy) % DEPTH] = req.item;
                        occupancy++;
                        due_results.push_back(make_result('0, '0, 1'b0, ST_OK, 1'b1));
                    end
                end
                REQ_DEQ:
                begin
                    if (occupancy == 0)
                    begin
                        due_results.push_back(make_result('0, '0, 1'b0, ST_EMPTY, 1'b1));
                    end
                    else
                    begin
                        due_results.push_back(make_result(ring[head_idx], '0, 1'b0,
                                                          ST_OK, 1'b1));
                        head_idx = (head_idx + 1) % DEPTH;
                        occupancy--;
                    end
                end
                REQ_SEARCH:
                begin
                    if (occupancy == 0)
                    begin
                        due_results.push_back(make_result('0, '0, 1'b0, ST_EMPTY, 1'b1));
                    end
                    else
                    begin
                        // newest entry is position 0, first match wins
                        for (int i = 0; i < occupancy && !hit; i++)
                        begin
                            slot = (head_idx + occupancy - 1 - i) % DEPTH;
                            if (ring[slot] == req.item)
                            begin
                                hit = 1'b1;
                                due_results.push_back(make_result('0, POS_W'(i), 1'b1,
                                                                  ST_OK, 1'b1));
                            end
                        end
                        if (!hit)
                        begin
                            due_results.push_back(make_result('0, '0, 1'b0, ST_OK, 1'b1));
                        end
                    end
                end
                REQ_CLEAR:
                begin
                    if (occupancy == 0)
                    begin
                        due_results.push_back(make_result('0, '0, 1'b0, ST_EMPTY, 1'b1));
                    end
                    else
                    begin
                        // drain oldest first, last flag on the final entry
                        for (int i = 0; i < occupancy; i++)
                        begin
                            due_results.push_back(make_result(ring[(head_idx + i) % DEPTH],
                                                              '0, 1'b0, ST_OK,
                                                              (i + 1 == occupancy)));
                        end
                    end
                    occupancy = 0;
                    head_idx  = 0;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Watch both channels: predict on input transactions, compare on output ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx  = 0;
            occupancy = 0;
            due_results.delete();
            pending   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                run_queue_request(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("%0t: unexpected result value=%h pos=%0d found=%b st=%0d last=%b",
                                 $time, out_data.value_out, out_data.position,
                                 out_data.found, out_data.status, out_data.last);
                    end
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_data.value_out !== want.value_out ||
                        out_data.position  !== want.position  ||
                        out_data.found     !== want.found     ||
                        out_data.status    !== want.status    ||
                        out_data.last      !== want.last)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $write("%0t: mismatch exp value=%h pos=%0d found=%b st=%0d ",
                                   $time, want.value_out, want.position, want.found,
                                   want.status);
                            $display("last=%b, got value=%h pos=%0d found=%b st=%0d last=%b",
                                     want.last, out_data.value_out, out_data.position,
                                     out_data.found, out_data.status, out_data.last);
                        end
                    end
                end
            end
            pending <= due_results.size();
        end
    end

endmodule

// ===== dv/tb_fifo_queue_with_search.sv =====
`timescale 1ns / 1ps

module tb_fifo_queue_with_search;
    import fqs_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 90;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    logic idle_on     = 1'b1;
    int   sent        = 0;
    int   cycle_count = 0;
    int   pending;
    int   fail_count;

    fifo_queue_with_search #(.DEPTH(DEPTH)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    fifo_search_checker #(.DEPTH(DEPTH)) u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= !(idle_on && $urandom_range(99) < 15);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Byte values drawn from a small set half the time so searches hit
    function automatic logic [DATA_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h3C;
            1:       return 8'hC3;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Present one request and hold it until the block accepts it
    task automatic send_req(input logic [1:0] kind, input logic [DATA_W-1:0] b);
        in_t req;
        begin
            req.req_type = kind;
            req.item     = b;
            if (idle_on && $urandom_range(99) < 15)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < 50) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= req;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            sent++;
        end
    endtask

    initial
    begin
        int random_base;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty cases, duplicates, hit and miss positions, drains
        send_req(REQ_DEQ, 8'h00);
        send_req(REQ_SEARCH, 8'h00);
        send_req(REQ_CLEAR, 8'h00);
        send_req(REQ_ENQ, 8'h00);
        send_req(REQ_ENQ, 8'hFF);
        send_req(REQ_ENQ, 8'hA5);
        send_req(REQ_ENQ, 8'h5A);
        send_req(REQ_ENQ, 8'hA5);
        send_req(REQ_SEARCH, 8'hA5);
        send_req(REQ_SEARCH, 8'h00);
        send_req(REQ_SEARCH, 8'hFF);
        send_req(REQ_SEARCH, 8'h7E);
        send_req(REQ_DEQ, 8'hFF);
        send_req(REQ_SEARCH, 8'h00);
        send_req(REQ_CLEAR, 8'hFF);
        send_req(REQ_DEQ, 8'h00);
        send_req(REQ_ENQ, 8'h81);
        send_req(REQ_SEARCH, 8'h81);
        send_req(REQ_CLEAR, 8'h00);

        // Random: start with a fill past full, no idling for a while
        random_base = sent;
        idle_on <= 1'b0;
        repeat (DEPTH + 1) send_req(REQ_ENQ, pick_byte());
        while (sent < random_base + RANDOM_ITEMS)
        begin
            if (sent >= random_base + 45)
            begin
                idle_on <= 1'b1;
            end
            case ($urandom_range(9))
                0, 1, 2: repeat ($urandom_range(1, 12)) send_req(REQ_ENQ, pick_byte());
                3, 4:    repeat ($urandom_range(1, 4)) send_req(REQ_SEARCH, pick_byte());
                5, 6:    repeat ($urandom_range(1, 6)) send_req(REQ_DEQ, pick_byte());
                7:       send_req(REQ_CLEAR, pick_byte());
                default: send_req(2'($urandom_range(3)), 8'($urandom_range(255)));
            endcase
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then let the block settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
